// File: design/fixed_block_pool_allocator_macros.svh
// Assertion macros for the pool allocator checker.
// Depends on nothing; each macro expects signals clk and rst in scope.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pool allocator check failed");

// Next-cycle implication, disabled during reset
`define FPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pool allocator check failed");

`endif

// File: design/fpa_pkg.sv
// Shared types, codes and widths for the fixed block pool allocator.
// Depends on nothing; used by the divider, the top level and the checker.
package fpa_pkg;

  localparam int DEFAULT_MAX_SLOTS = 1024;

  // Fixed field widths
  localparam int ADDR_W      = 32;
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 16;
  localparam int ALIGN_W     = 8;
  localparam int OP_W        = 2;
  localparam int INDEX_OUT_W = 10;
  localparam int STATUS_W    = 3;
  localparam int LIVE_W      = 11;
  localparam int CFG_IDX_W   = 2;

  // Divider widths
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_ALIGNMENT = 2'd3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOTHING   = 3'd4;

  // Register reset values
  localparam logic [SIZE_W-1:0]  RESET_OBJECT_SIZE      = 16'd16;
  localparam logic [ALIGN_W-1:0] RESET_OBJECT_ALIGNMENT = 8'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC_READ,
    ST_FREE_DIV,
    ST_CLEAR_DIV,
    ST_CLEAR_LINK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// File: design/fpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/fpa_div.sv
// Restoring divider, one quotient bit per cycle, for the pool allocator.
// Depends on fpa_pkg for widths and the request/response structs.
module fpa_div (
  input  logic              clk,
  input  logic              rst,
  input  fpa_pkg::div_req_t req,
  output fpa_pkg::div_rsp_t rsp
);
  import fpa_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      step;
  logic [DIVIDEND_W-1:0] quot;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One trial subtraction per step
  always_comb begin
    shifted = {rem, quot[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  // Sequence the steps and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (step == LAST_STEP)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift quotient and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      step    <= '0;
      quot    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      step <= step + 1'b1;
      quot <= {quot[DIVIDEND_W-2:0], fits};
      rem  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

// File: design/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free list of slot indices in a link RAM.
// Allocate: decode, a link RAM read of the new list head, then the result.
// Free: the one-bit-per-cycle divider turns an address into a slot index.
// Clear: a division for the slot count, then one slot per cycle
// through the link RAM write port. One item is in work at a time.
// Reset (synchronous) empties the pool; the link RAM holds nothing until a clear.
module fixed_block_pool_allocator #(
  parameter int MAX_SLOTS = fpa_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpa_pkg::DATA_W-1:0]      cfg_data,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [fpa_pkg::OP_W-1:0]        operation,
  input  logic [fpa_pkg::SIZE_W-1:0]      request_size,
  input  logic [fpa_pkg::ALIGN_W-1:0]     request_alignment,
  input  logic [fpa_pkg::ADDR_W-1:0]      free_address,
  // response channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [fpa_pkg::ADDR_W-1:0]      block_address,
  output logic [fpa_pkg::INDEX_OUT_W-1:0] slot_index,
  output logic [fpa_pkg::STATUS_W-1:0]    status,
  output logic [fpa_pkg::LIVE_W-1:0]      live_allocations,
  output logic [fpa_pkg::DATA_W-1:0]      bytes_in_use
);
  import fpa_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(MAX_SLOTS);

  state_t state, state_next;

  // configuration registers
  logic [ADDR_W-1:0]  base_address;
  logic [DATA_W-1:0]  region_size;
  logic [SIZE_W-1:0]  object_size;
  logic [ALIGN_W-1:0] object_alignment;

  // pool state
  logic [SLOT_W-1:0] list_head;
  logic [SLOT_W-1:0] slot_count;
  logic [ADDR_W-1:0] aligned_start;
  logic [LIVE_W-1:0] allocation_count;
  logic [DATA_W-1:0] used_bytes;

  // captured item and result under construction
  logic [OP_W-1:0]        op_code;
  logic [SIZE_W-1:0]      req_size;
  logic [ALIGN_W-1:0]     req_align;
  logic [ADDR_W-1:0]      req_addr;
  logic [ADDR_W-1:0]      res_address;
  logic [INDEX_OUT_W-1:0] res_index;
  logic [STATUS_W-1:0]    res_status;
  logic                   res_zero_counts;
  logic [PROD_W-1:0]      product;
  logic [SLOT_W-1:0]      link_ptr;

  // link RAM and divider
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // decode and check terms
  logic [IDX_W-1:0]   head_idx;
  logic               alloc_mismatch;
  logic               list_empty;
  logic               free_bad_base;
  logic [ADDR_W-1:0]  free_offset;
  logic               align_pow2;
  logic [ALIGN_W-1:0] align_mask;
  logic [ALIGN_W-1:0] adj;
  logic               clear_has_div;
  logic               free_ok;
  logic [SLOT_W-1:0]  sat_count;
  logic [SLOT_W-1:0]  link_next;
  logic               link_last;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign head_idx  = list_head[IDX_W-1:0];
  assign out_free  = !rsp_valid || !rsp_stall;

  // Checks on the captured item and the rebuild geometry
  always_comb begin
    alloc_mismatch = (req_size == '0) || (req_size != object_size) ||
                     (req_align != object_alignment);
    list_empty     = (list_head >= NO_SLOT);
    free_bad_base  = (object_size == '0) || (req_addr < aligned_start);
    free_offset    = req_addr - aligned_start;
    align_mask     = object_alignment - 1'b1;
    align_pow2     = (object_alignment != '0) && ((object_alignment & align_mask) == '0);
    adj            = align_pow2 ? ((object_alignment - (base_address[ALIGN_W-1:0] & align_mask))
                                   & align_mask) : '0;
    clear_has_div  = (object_size != '0) && (region_size > DATA_W'(adj));
    free_ok        = (div_rsp.remainder == '0) &&
                     (div_rsp.quotient < DIVIDEND_W'(slot_count));
    sat_count      = (div_rsp.quotient > DIVIDEND_W'(MAX_SLOTS)) ? NO_SLOT
                                                                 : SLOT_W'(div_rsp.quotient);
    link_next      = link_ptr + 1'b1;
    link_last      = (link_next == slot_count);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (op_code)
          OP_ALLOC: state_next = (alloc_mismatch || list_empty) ? ST_RESP : ST_ALLOC_READ;
          OP_FREE: begin
            state_next = ((allocation_count == '0) || free_bad_base) ? ST_RESP : ST_FREE_DIV;
          end
          OP_CLEAR: state_next = clear_has_div ? ST_CLEAR_DIV : ST_RESP;
          default: state_next = ST_RESP;
        endcase
      end
      ST_ALLOC_READ: state_next = ST_RESP;
      ST_FREE_DIV: begin
        if (div_rsp.done) state_next = ST_RESP;
      end
      ST_CLEAR_DIV: begin
        if (div_rsp.done) state_next = (sat_count != '0) ? ST_CLEAR_LINK : ST_RESP;
      end
      ST_CLEAR_LINK: begin
        if (link_last) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake, RAM and divider controls
  always_comb begin
    req_stall = (state != ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = link_ptr[IDX_W-1:0];
    ram_wdata = (link_next < slot_count) ? link_next : NO_SLOT;
    div_req.start    = 1'b0;
    div_req.divisor  = object_size;
    div_req.dividend = (op_code == OP_CLEAR) ? (region_size - DATA_W'(adj)) : free_offset;
    case (state)
      ST_DECODE: begin
        div_req.start = ((op_code == OP_FREE) && (allocation_count != '0) && !free_bad_base) ||
                        ((op_code == OP_CLEAR) && clear_has_div);
      end
      ST_FREE_DIV: begin
        ram_we    = div_rsp.done && free_ok;
        ram_waddr = div_rsp.quotient[IDX_W-1:0];
        ram_wdata = list_head;
      end
      ST_CLEAR_LINK: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  // Control state, pool state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      base_address     <= '0;
      region_size      <= '0;
      object_size      <= RESET_OBJECT_SIZE;
      object_alignment <= RESET_OBJECT_ALIGNMENT;
      list_head        <= NO_SLOT;
      slot_count       <= '0;
      aligned_start    <= '0;
      allocation_count <= '0;
      used_bytes       <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_ADDRESS:     base_address     <= cfg_data;
          CFG_REGION_SIZE:      region_size      <= cfg_data;
          CFG_OBJECT_SIZE:      object_size      <= cfg_data[SIZE_W-1:0];
          CFG_OBJECT_ALIGNMENT: object_alignment <= cfg_data[ALIGN_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_DECODE: begin
          if (op_code == OP_CLEAR) begin
            aligned_start    <= base_address + ADDR_W'(adj);
            allocation_count <= '0;
            used_bytes       <= '0;
            if (!clear_has_div) begin
              slot_count <= '0;
              list_head  <= NO_SLOT;
            end
          end
        end
        ST_ALLOC_READ: begin
          list_head        <= ram_rdata;
          used_bytes       <= used_bytes + DATA_W'(object_size);
          allocation_count <= allocation_count + 1'b1;
        end
        ST_FREE_DIV: begin
          if (div_rsp.done && free_ok) begin
            list_head        <= SLOT_W'(div_rsp.quotient);
            used_bytes       <= used_bytes - DATA_W'(object_size);
            allocation_count <= allocation_count - 1'b1;
          end
        end
        ST_CLEAR_DIV: begin
          if (div_rsp.done) begin
            slot_count <= sat_count;
            list_head  <= (sat_count != '0) ? '0 : NO_SLOT;
          end
        end
        default: ;
      endcase
      // present the result, drop it once taken
      if ((state == ST_RESP) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Captured item, result fields and sweep pointer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_code   <= operation;
          req_size  <= request_size;
          req_align <= request_alignment;
          req_addr  <= free_address;
        end
      end
      ST_DECODE: begin
        res_address     <= '0;
        res_index       <= '0;
        res_status      <= STATUS_OK;
        res_zero_counts <= !(op_code inside {OP_ALLOC, OP_FREE, OP_CLEAR});
        product         <= head_idx * object_size;
        link_ptr        <= '0;
        case (op_code)
          OP_ALLOC: begin
            if (alloc_mismatch) res_status <= STATUS_MISMATCH;
            else if (list_empty) res_status <= STATUS_EXHAUSTED;
          end
          OP_FREE: begin
            if (allocation_count == '0) res_status <= STATUS_NOTHING;
            else if (free_bad_base) res_status <= STATUS_BAD_FREE;
          end
          default: ;
        endcase
      end
      ST_ALLOC_READ: begin
        res_address <= aligned_start + ADDR_W'(product);
        res_index   <= INDEX_OUT_W'(head_idx);
      end
      ST_FREE_DIV: begin
        if (div_rsp.done) begin
          if (free_ok) res_index <= INDEX_OUT_W'(div_rsp.quotient);
          else res_status <= STATUS_BAD_FREE;
        end
      end
      ST_CLEAR_LINK: link_ptr <= link_next;
      ST_RESP: begin
        if (out_free) begin
          block_address    <= res_address;
          slot_index       <= res_index;
          status           <= res_status;
          live_allocations <= res_zero_counts ? '0 : allocation_count;
          bytes_in_use     <= res_zero_counts ? '0 : used_bytes;
        end
      end
      default: ;
    endcase
  end

  fpa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_idx),
    .rdata (ram_rdata)
  );

  fpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// File: design/fpa_checker.sv
// Port-level checks for the pool allocator, bound to the top level.
// Depends on fpa_pkg and fixed_block_pool_allocator_macros.svh.
`include "fixed_block_pool_allocator_macros.svh"

module fpa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic [fpa_pkg::ADDR_W-1:0]      block_address,
  input logic [fpa_pkg::INDEX_OUT_W-1:0] slot_index,
  input logic [fpa_pkg::STATUS_W-1:0]    status,
  input logic [fpa_pkg::LIVE_W-1:0]      live_allocations
);
  import fpa_pkg::*;

  // a stalled result holds
  `FPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
    rsp_valid && $stable(block_address) && $stable(status) && $stable(slot_index))

  // one item in work: an accepted item blocks the next
  `FPA_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

  // a failed item hands out no slot
  `FPA_ASSERT_NOW(a_fail_no_slot, rsp_valid && (status != STATUS_OK),
    (block_address == '0) && (slot_index == '0))

  // a free with nothing allocated reports an empty count
  `FPA_ASSERT_NOW(a_nothing_live, rsp_valid && (status == STATUS_NOTHING),
    live_allocations == '0)

endmodule

bind fixed_block_pool_allocator fpa_checker u_fpa_checker (.*);
